FILE: hdl/ifd_pkg.sv
// Shared constants, types and the CORDIC angle table for the I/Q frequency discriminator.
`timescale 1ns / 1ps
`default_nettype none

package ifd_pkg;

   // Field and register widths
   localparam int SAMPLE_W    = 16;
   localparam int ACC_LEN_W   = 9;
   localparam int ITD_W       = 20;
   localparam int FREQ_W      = 20;
   localparam int MAX_ACC_LEN = 256;
   localparam int CNT_W       = $clog2(MAX_ACC_LEN + 1);
   localparam int ACC_W       = 41;

   // CORDIC sizing: vector grows by the CORDIC gain and the half-turn fold
   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);
   localparam int XY_W         = ACC_W + 3;
   localparam int ANG_W        = 18;
   localparam int TABLE_IDX_W  = 5;

   // Shared multiplier and output rounding
   localparam int MUL_A_W    = ANG_W;
   localparam int MUL_B_W    = ITD_W + 1;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int RND_W      = PROD_W + 1;
   localparam int FRAC_BITS  = 16;
   localparam int SHIFTED_W  = RND_W - FRAC_BITS;
   localparam int ROUND_HALF = 2 ** (FRAC_BITS - 1);
   localparam int FREQ_MAX   = 2 ** (FREQ_W - 1) - 1;
   localparam int FREQ_MIN   = -(2 ** (FREQ_W - 1));

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 20;
   localparam logic [CSR_INDEX_W-1:0] REG_ACC_LEN       = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_INV_TIME_DIFF = 1'd1;

   // Reset values of the registers
   localparam logic [ACC_LEN_W-1:0] ACC_LEN_RESET = 9'd1;
   localparam logic [ITD_W-1:0]     ITD_RESET     = 20'd256;

   // Multiply-accumulate sequence steps
   localparam logic [STEP_W-1:0] MAC_II   = STEP_W'(0);
   localparam logic [STEP_W-1:0] MAC_QQ   = STEP_W'(1);
   localparam logic [STEP_W-1:0] MAC_IQ   = STEP_W'(2);
   localparam logic [STEP_W-1:0] MAC_QI   = STEP_W'(3);
   localparam logic [STEP_W-1:0] MAC_LAST = STEP_W'(4);
   localparam logic [STEP_W-1:0] ROT_LAST = STEP_W'(CORDIC_STEPS - 1);

   localparam logic signed [ANG_W-1:0] HALF_TURN = ANG_W'(32768);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DECIDE,
      ST_ROTATE,
      ST_SCALE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic              take_first;
      logic              take_second;
      logic              mac_en;
      logic              decide;
      logic              rotate;
      logic              scale;
      logic              load_rsp;
      logic [STEP_W-1:0] step;
   } cmd_type;

   typedef struct packed {
      logic hit;
   } status_type;

   // atan(2^-s) in units of 2^-16 turn, rounded
   function automatic logic signed [ANG_W-1:0] turn_angle(input logic [TABLE_IDX_W-1:0] idx);
      logic signed [ANG_W-1:0] angle;
      case (idx)
         5'd0:    angle = ANG_W'(8192);
         5'd1:    angle = ANG_W'(4836);
         5'd2:    angle = ANG_W'(2555);
         5'd3:    angle = ANG_W'(1297);
         5'd4:    angle = ANG_W'(651);
         5'd5:    angle = ANG_W'(326);
         5'd6:    angle = ANG_W'(163);
         5'd7:    angle = ANG_W'(81);
         5'd8:    angle = ANG_W'(41);
         5'd9:    angle = ANG_W'(20);
         5'd10:   angle = ANG_W'(10);
         5'd11:   angle = ANG_W'(5);
         5'd12:   angle = ANG_W'(3);
         5'd13:   angle = ANG_W'(1);
         5'd14:   angle = ANG_W'(1);
         default: angle = '0;
      endcase
      return angle;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/ifd_dp.sv
// Datapath: sample registers, accumulators, iterative CORDIC, scaling multiply, result register.
`timescale 1ns / 1ps
`default_nettype none

module ifd_dp (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire ifd_pkg::cmd_type                     cmd,
   output ifd_pkg::status_type                       status,
   input  wire logic signed [ifd_pkg::SAMPLE_W-1:0]  req_i_sample,
   input  wire logic signed [ifd_pkg::SAMPLE_W-1:0]  req_q_sample,
   input  wire logic                                 csr_we,
   input  wire logic [ifd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [ifd_pkg::CSR_DATA_W-1:0]       csr_data,
   output logic                                      rsp_ready_res,
   output logic signed [ifd_pkg::FREQ_W-1:0]         rsp_freq_err
);

   logic [ifd_pkg::ACC_LEN_W-1:0]          acc_len_ff;
   logic [ifd_pkg::ITD_W-1:0]              itd_ff;
   logic signed [ifd_pkg::SAMPLE_W-1:0]    prev_i_ff, prev_i_in;
   logic signed [ifd_pkg::SAMPLE_W-1:0]    prev_q_ff, prev_q_in;
   logic signed [ifd_pkg::SAMPLE_W-1:0]    cur_i_ff;
   logic signed [ifd_pkg::SAMPLE_W-1:0]    cur_q_ff;
   logic signed [ifd_pkg::ACC_W-1:0]       dot_ff, dot_in;
   logic signed [ifd_pkg::ACC_W-1:0]       cross_ff, cross_in;
   logic [ifd_pkg::CNT_W-1:0]              count_ff, count_in;
   logic [ifd_pkg::CNT_W-1:0]              count_plus;
   logic [ifd_pkg::CNT_W-1:0]              len_eff;
   logic                                   hit;
   logic                                   hit_ff;
   logic                                   zero_ff;
   logic signed [ifd_pkg::XY_W-1:0]        x_ff, x_in;
   logic signed [ifd_pkg::XY_W-1:0]        y_ff, y_in;
   logic signed [ifd_pkg::ANG_W-1:0]       z_ff, z_in;
   logic signed [ifd_pkg::XY_W-1:0]        dot_ext, cross_ext, dx, dy;
   logic signed [ifd_pkg::ANG_W-1:0]       turn;
   logic signed [ifd_pkg::MUL_A_W-1:0]     mul_a;
   logic signed [ifd_pkg::MUL_B_W-1:0]     mul_b;
   logic signed [ifd_pkg::PROD_W-1:0]      mul_p;
   logic signed [ifd_pkg::PROD_W-1:0]      prod_ff;
   logic signed [ifd_pkg::ACC_W-1:0]       prod_ext;
   logic signed [ifd_pkg::RND_W-1:0]       rounded;
   logic signed [ifd_pkg::SHIFTED_W-1:0]   shifted;
   logic signed [ifd_pkg::FREQ_W-1:0]      freq_sat;
   logic                                   rsp_ready_res_ff;
   logic signed [ifd_pkg::FREQ_W-1:0]      rsp_freq_err_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_len_ff <= ifd_pkg::ACC_LEN_RESET;
         itd_ff     <= ifd_pkg::ITD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            ifd_pkg::REG_ACC_LEN:       acc_len_ff <= csr_data[ifd_pkg::ACC_LEN_W-1:0];
            ifd_pkg::REG_INV_TIME_DIFF: itd_ff     <= csr_data[ifd_pkg::ITD_W-1:0];
            default: ;
         endcase
      end
   end

   // Select operands of the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (cmd.scale) begin
         mul_a = zero_ff ? '0 : z_ff;
         mul_b = $signed({1'b0, itd_ff});
      end else begin
         case (cmd.step)
            ifd_pkg::MAC_II: begin
               mul_a = ifd_pkg::MUL_A_W'(cur_i_ff);
               mul_b = ifd_pkg::MUL_B_W'(prev_i_ff);
            end
            ifd_pkg::MAC_QQ: begin
               mul_a = ifd_pkg::MUL_A_W'(cur_q_ff);
               mul_b = ifd_pkg::MUL_B_W'(prev_q_ff);
            end
            ifd_pkg::MAC_IQ: begin
               mul_a = ifd_pkg::MUL_A_W'(prev_i_ff);
               mul_b = ifd_pkg::MUL_B_W'(cur_q_ff);
            end
            ifd_pkg::MAC_QI: begin
               mul_a = ifd_pkg::MUL_A_W'(cur_i_ff);
               mul_b = ifd_pkg::MUL_B_W'(prev_q_ff);
            end
            default: ;
         endcase
      end
      mul_p = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (cmd.mac_en || cmd.scale) begin
         prod_ff <= mul_p;
      end
   end

   // Effective length and pair count
   always_comb begin
      if (acc_len_ff == '0) begin
         len_eff = ifd_pkg::CNT_W'(1);
      end else if (acc_len_ff > ifd_pkg::ACC_LEN_W'(ifd_pkg::MAX_ACC_LEN)) begin
         len_eff = ifd_pkg::CNT_W'(ifd_pkg::MAX_ACC_LEN);
      end else begin
         len_eff = ifd_pkg::CNT_W'(acc_len_ff);
      end
      count_plus = count_ff + ifd_pkg::CNT_W'(1);
      hit        = (count_plus >= len_eff);
      count_in   = count_ff;
      if (cmd.decide) begin
         count_in = hit ? '0 : count_plus;
      end
   end

   assign status.hit = hit;

   // Accumulate the product of the previous step; clear after an estimate
   always_comb begin
      prod_ext = ifd_pkg::ACC_W'(prod_ff);
      dot_in   = dot_ff;
      cross_in = cross_ff;
      if (cmd.mac_en) begin
         case (cmd.step)
            ifd_pkg::MAC_QQ,
            ifd_pkg::MAC_IQ:   dot_in   = dot_ff + prod_ext;
            ifd_pkg::MAC_QI:   cross_in = cross_ff + prod_ext;
            ifd_pkg::MAC_LAST: cross_in = cross_ff - prod_ext;
            default: ;
         endcase
      end
      if (cmd.decide && hit) begin
         dot_in   = '0;
         cross_in = '0;
      end
   end

   // Previous sample: direct for a first sample, from the held one after the MAC
   always_comb begin
      prev_i_in = prev_i_ff;
      prev_q_in = prev_q_ff;
      if (cmd.take_first) begin
         prev_i_in = req_i_sample;
         prev_q_in = req_q_sample;
      end else if (cmd.mac_en && cmd.step == ifd_pkg::MAC_LAST) begin
         prev_i_in = cur_i_ff;
         prev_q_in = cur_q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_i_ff <= ifd_pkg::SAMPLE_W'(1);
         prev_q_ff <= '0;
         dot_ff    <= '0;
         cross_ff  <= '0;
         count_ff  <= '0;
      end else begin
         prev_i_ff <= prev_i_in;
         prev_q_ff <= prev_q_in;
         dot_ff    <= dot_in;
         cross_ff  <= cross_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_second) begin
         cur_i_ff <= req_i_sample;
         cur_q_ff <= req_q_sample;
      end
   end

   // CORDIC vectoring: fold left half-plane, then one micro-rotation per cycle
   always_comb begin
      dot_ext   = ifd_pkg::XY_W'(dot_ff);
      cross_ext = ifd_pkg::XY_W'(cross_ff);
      dx        = y_ff >>> cmd.step;
      dy        = x_ff >>> cmd.step;
      turn      = ifd_pkg::turn_angle(ifd_pkg::TABLE_IDX_W'(cmd.step));
      x_in      = x_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      if (cmd.decide) begin
         if (dot_ff[ifd_pkg::ACC_W-1]) begin
            x_in = -dot_ext;
            y_in = -cross_ext;
            z_in = cross_ff[ifd_pkg::ACC_W-1] ? -ifd_pkg::HALF_TURN : ifd_pkg::HALF_TURN;
         end else begin
            x_in = dot_ext;
            y_in = cross_ext;
            z_in = '0;
         end
      end else if (cmd.rotate) begin
         if (y_ff[ifd_pkg::XY_W-1]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - turn;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + turn;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      if (cmd.decide) begin
         hit_ff  <= hit;
         zero_ff <= (dot_ff == '0) && (cross_ff == '0);
      end
   end

   // Round to 2^-8 Hz and saturate
   always_comb begin
      rounded = ifd_pkg::RND_W'(prod_ff) + ifd_pkg::RND_W'(ifd_pkg::ROUND_HALF);
      shifted = $signed(rounded[ifd_pkg::RND_W-1:ifd_pkg::FRAC_BITS]);
      if (shifted > $signed(ifd_pkg::SHIFTED_W'(ifd_pkg::FREQ_MAX))) begin
         freq_sat = ifd_pkg::FREQ_W'(ifd_pkg::FREQ_MAX);
      end else if (shifted < $signed(ifd_pkg::SHIFTED_W'(ifd_pkg::FREQ_MIN))) begin
         freq_sat = ifd_pkg::FREQ_W'(ifd_pkg::FREQ_MIN);
      end else begin
         freq_sat = ifd_pkg::FREQ_W'(shifted);
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ready_res_ff <= hit_ff;
         rsp_freq_err_ff  <= hit_ff ? freq_sat : '0;
      end
   end

   assign rsp_ready_res = rsp_ready_res_ff;
   assign rsp_freq_err  = rsp_freq_err_ff;

endmodule

`default_nettype wire

FILE: hdl/ifd_ctrl.sv
// Controller: sequences capture, multiply-accumulate, CORDIC, scaling and result handoff.
`timescale 1ns / 1ps
`default_nettype none

module ifd_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_kind,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output ifd_pkg::cmd_type           cmd,
   input  wire ifd_pkg::status_type   status
);

   ifd_pkg::state_type          state_ff, state_in;
   logic [ifd_pkg::STEP_W-1:0]  step_ff, step_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state and step counter
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ifd_pkg::ST_IDLE: begin
            step_in = '0;
            if (req_valid && req_kind) begin
               state_in = ifd_pkg::ST_MAC;
            end
         end
         ifd_pkg::ST_MAC: begin
            if (step_ff == ifd_pkg::MAC_LAST) begin
               state_in = ifd_pkg::ST_DECIDE;
               step_in  = '0;
            end else begin
               step_in = step_ff + ifd_pkg::STEP_W'(1);
            end
         end
         ifd_pkg::ST_DECIDE: begin
            step_in  = '0;
            state_in = status.hit ? ifd_pkg::ST_ROTATE : ifd_pkg::ST_EMIT;
         end
         ifd_pkg::ST_ROTATE: begin
            if (step_ff == ifd_pkg::ROT_LAST) begin
               state_in = ifd_pkg::ST_SCALE;
               step_in  = '0;
            end else begin
               step_in = step_ff + ifd_pkg::STEP_W'(1);
            end
         end
         ifd_pkg::ST_SCALE: begin
            state_in = ifd_pkg::ST_EMIT;
         end
         ifd_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = ifd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ifd_pkg::ST_IDLE;
            step_in  = '0;
         end
      endcase
   end

   // Datapath commands and handshake outputs
   always_comb begin
      cmd             = '0;
      cmd.step        = step_ff;
      cmd.take_first  = (state_ff == ifd_pkg::ST_IDLE) && req_valid && !req_kind;
      cmd.take_second = (state_ff == ifd_pkg::ST_IDLE) && req_valid && req_kind;
      cmd.mac_en      = (state_ff == ifd_pkg::ST_MAC);
      cmd.decide      = (state_ff == ifd_pkg::ST_DECIDE);
      cmd.rotate      = (state_ff == ifd_pkg::ST_ROTATE);
      cmd.scale       = (state_ff == ifd_pkg::ST_SCALE);
      cmd.load_rsp    = (state_ff == ifd_pkg::ST_EMIT) && out_free;
      req_stall       = (state_ff != ifd_pkg::ST_IDLE);
   end

   // Result valid: drop on handoff, raise on load
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ifd_pkg::ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");

   a_valid_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ifd_pkg::ST_EMIT))
      else $error("result valid raised outside emit");

   a_mac_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ifd_pkg::ST_MAC) |-> (step_ff <= ifd_pkg::MAC_LAST))
      else $error("MAC step out of range");

   a_rotate_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ifd_pkg::ST_ROTATE && step_ff == ifd_pkg::ROT_LAST)
         |=> (state_ff == ifd_pkg::ST_SCALE))
      else $error("CORDIC did not finish into scaling");
`endif

endmodule

`default_nettype wire

FILE: hdl/iq_frequency_error_discriminator.sv
// Top level of the I/Q frequency error discriminator: controller plus datapath.
//
//   Channel  Direction  Handshake               Payload
//   req      in         req_valid / req_stall   req_kind, req_i_sample, req_q_sample
//   rsp      out        rsp_valid / rsp_stall   rsp_ready_res, rsp_freq_err
//   csr      in         csr_valid / csr_ready   csr_index, csr_data
//
// A first sample is only captured on acceptance. A second sample is accepted, then runs
// the dot and cross terms through the shared multiplier, takes a decision and, when an
// estimate is due, runs the CORDIC_STEPS micro-rotations of the iterative CORDIC and
// one scaling multiply, and last loads the result register.
// Synchronous active-high reset restores config, accumulators, state; no clearing pass.
// A waiting result does not block a new transaction; only the next result waits.
`timescale 1ns / 1ps
`default_nettype none

module iq_frequency_error_discriminator (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_kind,
   input  wire logic signed [ifd_pkg::SAMPLE_W-1:0]  req_i_sample,
   input  wire logic signed [ifd_pkg::SAMPLE_W-1:0]  req_q_sample,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_ready_res,
   output logic signed [ifd_pkg::FREQ_W-1:0]         rsp_freq_err,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [ifd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [ifd_pkg::CSR_DATA_W-1:0]       csr_data
);

   ifd_pkg::cmd_type    cmd;
   ifd_pkg::status_type status;

   // Registers accept a write on any cycle
   assign csr_ready = 1'b1;

   ifd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   ifd_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_i_sample  (req_i_sample),
      .req_q_sample  (req_q_sample),
      .csr_we        (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rsp_ready_res (rsp_ready_res),
      .rsp_freq_err  (rsp_freq_err)
   );

endmodule

`default_nettype wire

FILE: verif/iq_frequency_error_discriminator_tb.sv
// Self-checking testbench for the I/Q frequency error discriminator.
`timescale 1ns / 1ps

module iq_frequency_error_discriminator_tb;

   localparam int CLK_PERIOD    = 8;
   localparam int RESET_CYCLES  = 11;
   localparam int IDLE_PCT      = 24;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 300;
   localparam int WATCHDOG      = 2000;

   localparam logic KIND_FIRST  = 1'b0;
   localparam logic KIND_SECOND = 1'b1;

   // atan(2^-s) in 2^-16 turn
   localparam int ATAN_TURNS [16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                      41, 20, 10, 5, 3, 1, 1, 0};
   localparam logic signed [ifd_pkg::SAMPLE_W-1:0] CORNER_SAMPLES [4] =
      '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};

   typedef struct {
      logic                                kind;
      logic signed [ifd_pkg::SAMPLE_W-1:0] i_val;
      logic signed [ifd_pkg::SAMPLE_W-1:0] q_val;
   } sample_type;

   typedef struct {
      logic                              ready;
      logic signed [ifd_pkg::FREQ_W-1:0] freq;
   } estimate_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                 req_valid    = 1'b0;
   logic                                 req_stall;
   logic                                 req_kind     = 1'b0;
   logic signed [ifd_pkg::SAMPLE_W-1:0]  req_i_sample = '0;
   logic signed [ifd_pkg::SAMPLE_W-1:0]  req_q_sample = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall    = 1'b0;
   logic                                 rsp_ready_res;
   logic signed [ifd_pkg::FREQ_W-1:0]    rsp_freq_err;
   logic                                 csr_valid    = 1'b0;
   logic                                 csr_ready;
   logic [ifd_pkg::CSR_INDEX_W-1:0]      csr_index    = '0;
   logic [ifd_pkg::CSR_DATA_W-1:0]       csr_data     = '0;

   sample_type   pending_samples[$];
   estimate_type freq_estimates[$];

   int unsigned samples_queued = 0;
   int unsigned samples_taken  = 0;
   int unsigned mismatches     = 0;
   int unsigned stuck_cycles   = 0;
   int unsigned hold_count     = 0;
   logic        steady         = 1'b0;
   logic        hold_request   = 1'b0;

   // Predictor state and register copies
   logic signed [ifd_pkg::SAMPLE_W-1:0] last_i     = 16'sd1;
   logic signed [ifd_pkg::SAMPLE_W-1:0] last_q     = '0;
   logic signed [ifd_pkg::ACC_W-1:0]    dot_sum    = '0;
   logic signed [ifd_pkg::ACC_W-1:0]    cross_sum  = '0;
   int unsigned                         pairs_seen = 0;
   logic [ifd_pkg::ACC_LEN_W-1:0]       len_reg    = ifd_pkg::ACC_LEN_RESET;
   logic [ifd_pkg::ITD_W-1:0]           itd_reg    = ifd_pkg::ITD_RESET;

   iq_frequency_error_discriminator dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_i_sample  (req_i_sample),
      .req_q_sample  (req_q_sample),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_ready_res (rsp_ready_res),
      .rsp_freq_err  (rsp_freq_err),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Vectoring CORDIC: angle of (x, y) in 2^-16 turn, with the half-turn fold
   function automatic logic signed [63:0] cordic_turns(input logic signed [63:0] y_in,
                                                       input logic signed [63:0] x_in);
      logic signed [63:0] x, y, z, dx, dy;
      x = x_in;
      y = y_in;
      z = '0;
      if (x == 0 && y == 0)
         return '0;
      if (x < 0) begin
         z = (y >= 0) ? 64'sd32768 : -64'sd32768;
         x = -x;
         y = -y;
      end
      for (int s = 0; s < ifd_pkg::CORDIC_STEPS; s++) begin
         dx = y >>> s;
         dy = x >>> s;
         if (y >= 0) begin
            x = x + dx;
            y = y - dy;
            z = z + 64'(ATAN_TURNS[s]);
         end else begin
            x = x - dx;
            y = y + dy;
            z = z - 64'(ATAN_TURNS[s]);
         end
      end
      return z;
   endfunction

   // Advance the discriminator state by one sample; queue the result of a second sample
   task automatic track_sample(input logic kind,
                               input logic signed [ifd_pkg::SAMPLE_W-1:0] si,
                               input logic signed [ifd_pkg::SAMPLE_W-1:0] sq);
      logic signed [63:0] dot_term, cross_term, z, scale, p, f;
      int unsigned        eff_len;
      estimate_type       est;
      if (kind == KIND_FIRST) begin
         last_i = si;
         last_q = sq;
      end else begin
         dot_term   = 64'(si) * 64'(last_i) + 64'(sq) * 64'(last_q);
         cross_term = 64'(last_i) * 64'(sq) - 64'(si) * 64'(last_q);
         dot_sum    = ifd_pkg::ACC_W'(64'(dot_sum) + dot_term);
         cross_sum  = ifd_pkg::ACC_W'(64'(cross_sum) + cross_term);
         last_i     = si;
         last_q     = sq;
         eff_len = 32'(len_reg);
         if (eff_len == 0)
            eff_len = 1;
         if (eff_len > ifd_pkg::MAX_ACC_LEN)
            eff_len = ifd_pkg::MAX_ACC_LEN;
         pairs_seen++;
         est.ready = 1'b0;
         est.freq  = '0;
         if (pairs_seen >= eff_len) begin
            z     = cordic_turns(64'(cross_sum), 64'(dot_sum));
            scale = 64'(itd_reg);
            p     = z * scale;
            f     = (p + 64'sd32768) >>> 16;
            if (f > ifd_pkg::FREQ_MAX)
               f = 64'(ifd_pkg::FREQ_MAX);
            if (f < ifd_pkg::FREQ_MIN)
               f = 64'(ifd_pkg::FREQ_MIN);
            est.ready  = 1'b1;
            est.freq   = f[ifd_pkg::FREQ_W-1:0];
            pairs_seen = 0;
            dot_sum    = '0;
            cross_sum  = '0;
         end
         freq_estimates.push_back(est);
      end
   endtask

   function automatic logic signed [ifd_pkg::SAMPLE_W-1:0] rand_sample();
      logic signed [ifd_pkg::SAMPLE_W-1:0] v;
      case ($urandom_range(3))
         0:       v = 16'($urandom_range(512)) - 16'd256;
         1:       v = CORNER_SAMPLES[$urandom_range(3)];
         default: v = 16'($urandom());
      endcase
      return v;
   endfunction

   task automatic add_sample(input logic kind, input int i_val, input int q_val);
      sample_type smp;
      smp.kind  = kind;
      smp.i_val = 16'(i_val);
      smp.q_val = 16'(q_val);
      pending_samples.push_back(smp);
      samples_queued++;
   endtask

   task automatic add_pair(input int i0, input int q0, input int i1, input int q1);
      add_sample(KIND_FIRST, i0, q0);
      add_sample(KIND_SECOND, i1, q1);
   endtask

   // Well-formed pairs with random content, with some stray samples mixed in
   task automatic add_pairs(input int n, input int noise_pct);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(99) < noise_pct)
            add_sample(1'($urandom()), rand_sample(), rand_sample());
         else
            add_pair(rand_sample(), rand_sample(), rand_sample(), rand_sample());
      end
   endtask

   // Wait for every queued sample and every result, then let the block go idle
   task automatic drain();
      do @(posedge clock);
      while (samples_taken != samples_queued || freq_estimates.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [ifd_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [ifd_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Sender: hold a stalled transaction, otherwise offer or idle at random
   always @(posedge clock) begin : driver
      sample_type next_sample;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_samples.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
            next_sample = pending_samples.pop_front();
            req_valid    <= 1'b1;
            req_kind     <= next_sample.kind;
            req_i_sample <= next_sample.i_val;
            req_q_sample <= next_sample.q_val;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: one long hold-off on request, otherwise random stalls
   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_request && hold_count < HOLD_CYCLES) begin
         rsp_stall <= 1'b1;
         hold_count++;
      end else begin
         rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // Observe all three channels, check results, and watch for a hang
   always @(posedge clock) begin : monitor
      estimate_type est;
      logic         moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (freq_estimates.size() == 0) begin
               mismatches++;
               $display("%0t: result expected none actual ready_res=%0b freq_err=%0d",
                        $time, rsp_ready_res, rsp_freq_err);
            end else begin
               est = freq_estimates.pop_front();
               if (rsp_ready_res !== est.ready) begin
                  mismatches++;
                  $display("%0t: ready_res expected %0b actual %0b",
                           $time, est.ready, rsp_ready_res);
               end
               if (rsp_freq_err !== est.freq) begin
                  mismatches++;
                  $display("%0t: freq_err expected %0d actual %0d",
                           $time, est.freq, rsp_freq_err);
               end
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            track_sample(req_kind, req_i_sample, req_q_sample);
            samples_taken++;
         end
         if (csr_valid && csr_ready) begin
            moved = 1'b1;
            if (csr_index == ifd_pkg::REG_ACC_LEN)
               len_reg = csr_data[ifd_pkg::ACC_LEN_W-1:0];
            else if (csr_index == ifd_pkg::REG_INV_TIME_DIFF)
               itd_reg = csr_data[ifd_pkg::ITD_W-1:0];
         end
         stuck_cycles = moved ? 0 : stuck_cycles + 1;
         if (stuck_cycles >= WATCHDOG) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: second sample against the reset previous sample, then key angles
      add_sample(KIND_SECOND, 32767, 0);
      add_pair(-32768, -32768, -32768, -32768);
      add_pair(32767, 32767, -32768, -32768);
      add_pair(0, 0, 0, 0);
      add_pair(100, 0, 0, 100);
      add_pair(100, 0, 0, -100);
      add_pair(100, 0, -100, -1);
      add_sample(KIND_SECOND, 32767, -32768);
      add_sample(KIND_FIRST, 5, 7);
      add_sample(KIND_FIRST, -3, 9);
      add_sample(KIND_SECOND, 9, 3);
      drain;

      // Largest scale: drive the output into saturation
      write_reg(ifd_pkg::REG_INV_TIME_DIFF, 20'hFFFFF);
      add_pair(32767, 32767, -32768, -32768);
      add_pair(100, 0, -100, -1);
      add_pair(100, 0, -100, 1);
      drain;

      // Zero length and zero scale
      write_reg(ifd_pkg::REG_ACC_LEN, 20'd0);
      write_reg(ifd_pkg::REG_INV_TIME_DIFF, 20'd0);
      add_pairs(6, 0);
      drain;

      // Longest accumulation with no idling on either side
      write_reg(ifd_pkg::REG_ACC_LEN, 20'd256);
      write_reg(ifd_pkg::REG_INV_TIME_DIFF, 20'($urandom()));
      steady = 1'b1;
      add_pairs(258, 0);
      drain;
      steady = 1'b0;

      // Lower the length while an accumulation is part way through
      write_reg(ifd_pkg::REG_ACC_LEN, 20'd200);
      add_pairs(150, 5);
      drain;
      write_reg(ifd_pkg::REG_ACC_LEN, 20'd10);
      add_pairs(30, 10);
      drain;

      // Length above the maximum clamps to the maximum
      write_reg(ifd_pkg::REG_ACC_LEN, 20'd511);
      write_reg(ifd_pkg::REG_INV_TIME_DIFF, 20'd256);
      add_pairs(256, 0);
      drain;

      // Random settings with short lengths; the first one holds off the receiver
      for (int p = 0; p < 6; p++) begin
         write_reg(ifd_pkg::REG_ACC_LEN, {11'($urandom()), 9'($urandom_range(8, 1))});
         if ($urandom_range(1))
            write_reg(ifd_pkg::REG_INV_TIME_DIFF, 20'($urandom()));
         else
            write_reg(ifd_pkg::REG_INV_TIME_DIFF, 20'($urandom_range(4096, 64)));
         if (p == 0)
            hold_request = 1'b1;
         add_pairs(40, 15);
         drain;
      end

      if (mismatches == 0 && freq_estimates.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/ifd_pkg.sv
hdl/ifd_dp.sv
hdl/ifd_ctrl.sv
hdl/iq_frequency_error_discriminator.sv
verif/iq_frequency_error_discriminator_tb.sv
